@@ rtl/core/qmm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Q15 matrix multiply unit: sizes, codes, shared types and
// address helpers. No dependencies.
package qmm_pkg;

  localparam int MAX_DIM   = 8;
  // The 3-bit index fields cap the usable matrix size at 8.
  localparam int DIM_LIM   = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int DIM_W     = $clog2(DIM_LIM);
  localparam int DEPTH     = DIM_LIM * DIM_LIM;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int IDX_W     = 3;
  localparam int OP_W      = 2;
  localparam int DIM_REG_W = 4;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = PROD_W + DIM_W + 1;
  localparam int Q_SHIFT   = 15;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [ELEM_W-1:0] Q15_SAT_MAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] Q15_SAT_MIN = 16'sh8000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_SIZE_ERR = 1'b1
  } status_t;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_ERR
  } seq_state_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0] a_rows;
    logic [DIM_REG_W-1:0] a_cols;
    logic [DIM_REG_W-1:0] b_rows;
    logic [DIM_REG_W-1:0] b_cols;
  } dims_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  // Last index in use for a dimension register: zero counts as one, and
  // anything above the store size counts as the store size.
  function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_REG_W-1:0] v);
    logic [DIM_REG_W-1:0] d;
    if (v == '0) begin
      d = DIM_REG_W'(1);
    end else if (v > DIM_REG_W'(DIM_LIM)) begin
      d = DIM_REG_W'(DIM_LIM);
    end else begin
      d = v;
    end
    return DIM_W'(d - DIM_REG_W'(1));
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    return ADDR_W'(int'(r) * DIM_LIM + int'(c));
  endfunction

endpackage

@@ rtl/core/qmm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module qmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/qmm_cfg_regs.sv @@
`timescale 1ns / 1ps
// APB-style register block holding the four matrix dimension registers.
// Depends on qmm_pkg.
module qmm_cfg_regs import qmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output dims_t                 dims
);

  dims_t    dims_r;
  cfg_reg_t sel;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign sel        = cfg_reg_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dims       = dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.a_rows <= DIM_REG_W'(8);
      dims_r.a_cols <= DIM_REG_W'(8);
      dims_r.b_rows <= DIM_REG_W'(8);
      dims_r.b_cols <= DIM_REG_W'(8);
    end else if (wr_en) begin
      unique case (sel)
        REG_A_ROWS: dims_r.a_rows <= cfg_pwdata[DIM_REG_W-1:0];
        REG_A_COLS: dims_r.a_cols <= cfg_pwdata[DIM_REG_W-1:0];
        REG_B_ROWS: dims_r.b_rows <= cfg_pwdata[DIM_REG_W-1:0];
        REG_B_COLS: dims_r.b_cols <= cfg_pwdata[DIM_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_A_ROWS: cfg_prdata = CFG_DATA_W'(dims_r.a_rows);
      REG_A_COLS: cfg_prdata = CFG_DATA_W'(dims_r.a_cols);
      REG_B_ROWS: cfg_prdata = CFG_DATA_W'(dims_r.b_rows);
      REG_B_COLS: cfg_prdata = CFG_DATA_W'(dims_r.b_cols);
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/qmm_mac.sv @@
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with the final shift by 15 and int16
// saturation. Depends on qmm_pkg.
module qmm_mac import qmm_pkg::*; (
  input  logic              clk,
  input  mac_ctrl_t         ctrl,
  input  logic [ELEM_W-1:0] a_elem,
  input  logic [ELEM_W-1:0] b_elem,
  output logic [ELEM_W-1:0] result
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_base;
  logic [ACC_W-Q_SHIFT-ELEM_W:0] upper;
  logic                     in_range;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= $signed(a_elem) * $signed(b_elem);
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_base + ACC_W'(prod_r);
    end
  end

  assign acc_base = ctrl.acc_first ? '0 : acc_r;

  // After the shift the value fits int16 only when every bit above the new
  // sign bit matches it.
  assign upper    = acc_r[ACC_W-1:Q_SHIFT+ELEM_W-1];
  assign in_range = (&upper) || !(|upper);

  always_comb begin
    if (in_range) begin
      result = acc_r[Q_SHIFT+ELEM_W-1:Q_SHIFT];
    end else if (acc_r[ACC_W-1]) begin
      result = Q15_SAT_MIN;
    end else begin
      result = Q15_SAT_MAX;
    end
  end

endmodule

@@ rtl/core/qmm_seq.sv @@
`timescale 1ns / 1ps
// Sequencer: takes load and compute requests, steps the row, column and
// inner-product counters, drives the stores and the MAC, and holds the
// output register. Depends on qmm_pkg.
module qmm_seq import qmm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dims_t             dims,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [ELEM_W-1:0] in_elem,
  output logic              we_a,
  output logic              we_b,
  output logic [ADDR_W-1:0] waddr,
  output logic [ELEM_W-1:0] wdata,
  output logic [ADDR_W-1:0] raddr_a,
  output logic [ADDR_W-1:0] raddr_b,
  output mac_ctrl_t         mac_ctrl,
  input  logic [ELEM_W-1:0] mac_result,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [ELEM_W-1:0] out_product,
  output logic [IDX_W-1:0]  out_row,
  output logic [IDX_W-1:0]  out_col,
  output logic              out_status,
  output logic              out_last
);

  seq_state_t state_r, state_nxt;

  logic [DIM_W-1:0] i_r, j_r, k_r;
  logic [DIM_W-1:0] nr_last_r, nk_last_r, nc_last_r;

  logic              out_valid_r;
  logic [ELEM_W-1:0] out_product_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic              out_status_r, out_last_r;

  logic accept, in_range, size_ok, slot_free, elem_last, k_last;
  logic is_load_a, is_load_b, is_compute;
  logic load_res, load_err;

  assign accept     = in_tvalid && in_tready;
  assign is_load_a  = op_t'(in_op) == OP_LOAD_A;
  assign is_load_b  = op_t'(in_op) == OP_LOAD_B;
  assign is_compute = op_t'(in_op) == OP_COMPUTE;
  assign in_range   = ((IDX_W + 1)'(in_row) < (IDX_W + 1)'(DIM_LIM)) &&
                      ((IDX_W + 1)'(in_col) < (IDX_W + 1)'(DIM_LIM));
  assign size_ok    = dims.a_cols == dims.b_rows;
  assign slot_free  = !out_valid_r || out_tready;
  assign elem_last  = (i_r == nr_last_r) && (j_r == nc_last_r);
  assign k_last     = k_r == nk_last_r;

  assign waddr = elem_addr(DIM_W'(in_row), DIM_W'(in_col));
  assign wdata = in_elem;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_compute) begin
          state_nxt = size_ok ? ST_READ : ST_ERR;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = k_last ? ST_EMIT : ST_READ;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = elem_last ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_tready          = 1'b0;
    we_a               = 1'b0;
    we_b               = 1'b0;
    mac_ctrl.mul_en    = 1'b0;
    mac_ctrl.acc_en    = 1'b0;
    mac_ctrl.acc_first = k_r == '0;
    load_res           = 1'b0;
    load_err           = 1'b0;
    raddr_a            = elem_addr(i_r, k_r);
    raddr_b            = elem_addr(k_r, j_r);
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        we_a      = accept && is_load_a && in_range;
        we_b      = accept && is_load_b && in_range;
      end
      ST_READ: ;
      ST_MUL:  mac_ctrl.mul_en = 1'b1;
      ST_ACC:  mac_ctrl.acc_en = 1'b1;
      ST_EMIT: load_res = slot_free;
      ST_ERR:  load_err = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      nr_last_r <= '0;
      nk_last_r <= '0;
      nc_last_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && accept && is_compute) begin
        i_r       <= '0;
        j_r       <= '0;
        k_r       <= '0;
        nr_last_r <= dim_last(dims.a_rows);
        nk_last_r <= dim_last(dims.a_cols);
        nc_last_r <= dim_last(dims.b_cols);
      end
      if (state_r == ST_ACC) begin
        k_r <= k_last ? '0 : k_r + DIM_W'(1);
      end
      if (load_res && !elem_last) begin
        if (j_r == nc_last_r) begin
          j_r <= '0;
          i_r <= i_r + DIM_W'(1);
        end else begin
          j_r <= j_r + DIM_W'(1);
        end
      end
    end
  end

  // Output register: a result waits here while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_res || load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_product_r <= mac_result;
      out_row_r     <= IDX_W'(i_r);
      out_col_r     <= IDX_W'(j_r);
      out_status_r  <= STATUS_OK;
      out_last_r    <= elem_last;
    end else if (load_err) begin
      out_product_r <= '0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      out_status_r  <= STATUS_SIZE_ERR;
      out_last_r    <= 1'b1;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_product = out_product_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_status  = out_status_r;
  assign out_last    = out_last_r;

  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (we_a || we_b) |-> (state_r == ST_IDLE && !(we_a && we_b)))
    else $error("store write outside idle or to both stores");

  a_k_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r <= nk_last_r))
    else $error("inner index ran past the column count");

  a_err_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_SIZE_ERR) |->
      (out_last_r && out_product_r == '0 && out_row_r == '0 && out_col_r == '0))
    else $error("malformed size-error result");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load_res && elem_last) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("compute run did not end with the last element");

endmodule

@@ rtl/core/q15_matrix_multiply_unit.sv @@
`timescale 1ns / 1ps
// Q15 matrix multiply unit: request stream in, product stream out, APB-style
// dimension registers. Depends on qmm_pkg, qmm_cfg_regs, qmm_seq, qmm_mac, qmm_ram.
//
// Usage:
//   Load requests (op 0 for A, op 1 for B) write one element at row/column and
//   are taken one per cycle while the unit is idle; indexes past the store size
//   are dropped. A compute request (op 2) checks a_cols against b_rows. On a
//   mismatch one result with status 1 and tlast set comes out. Otherwise the
//   a_rows x b_cols product elements come out in row-major order, tlast on the
//   final one. Op 3 is ignored.
//   Each product element takes one read, one multiply and one accumulate per
//   inner term through the single MAC and the one read port of each store,
//   then a step to load the output register, and in_tready is low for all of
//   a compute run. A size error goes from the idle state to the error state,
//   which loads it into the output register once that register is free.
//   When the receiver stalls, the finished result holds in the output register
//   and the sequencer waits before loading the next one.
//   Reset sets all four dimension registers to 8; the element stores are not
//   cleared, so every element that a compute run reads must be loaded first.
//   Registers must be written only while the unit is idle; no logic enforces it.
module q15_matrix_multiply_unit import qmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] row_index, [5:3] col_index, [21:6] element, [23:22] zero
  input  logic [23:0]           in_tdata,
  // [1:0] op
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] product, [18:16] out_row, [21:19] out_col, [23:22] zero
  output logic [23:0]           out_tdata,
  // [0] status
  output logic [0:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  dims_t             dims;
  mac_ctrl_t         mac_ctrl;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [ELEM_W-1:0] wdata, rdata_a, rdata_b, mac_result;
  logic [ELEM_W-1:0] out_product;
  logic [IDX_W-1:0]  out_row, out_col;
  logic              out_status;

  qmm_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .dims        (dims)
  );

  qmm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser[1:0]),
    .in_row      (in_tdata[2:0]),
    .in_col      (in_tdata[5:3]),
    .in_elem     (in_tdata[21:6]),
    .we_a        (we_a),
    .we_b        (we_b),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .mac_ctrl    (mac_ctrl),
    .mac_result  (mac_result),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_product (out_product),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_status  (out_status),
    .out_last    (out_tlast)
  );

  qmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  qmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  qmm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .a_elem (rdata_a),
    .b_elem (rdata_b),
    .result (mac_result)
  );

  assign out_tdata = {2'b00, out_col, out_row, out_product};
  assign out_tuser = out_status;

endmodule
